/* hw/rtl/ght_pkg.sv */
// Shared types and constants of the generational handle table.
`default_nettype none

package ght_pkg;

  // Request opcodes; codes above OP_CLEAR are rejected.
  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_RESOLVE = 3'd1,
    OP_RETIRE  = 3'd2,
    OP_COLLECT = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_REJECT     = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_QUEUE_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_ADD_GEN,
    S_SLOT,
    S_COL,
    S_MISC
  } state_t;

  localparam int FENCE_W     = 64;
  localparam int MAX_RESULTS = 16;
  localparam int COL_N_W     = $clog2(MAX_RESULTS + 1);

endpackage

`default_nettype wire

/* hw/rtl/ght_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // Hold read data until the next read.
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ght_out_reg.sv */
// Output register stage between the sequencer and the response channel.
`default_nettype none

module ght_out_reg #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  output logic             load_ready,
  input  logic [WIDTH-1:0] load_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             valid;
  logic [WIDTH-1:0] data;

  assign load_ready = !valid || out_ready;
  assign out_valid  = valid;
  assign out_data   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_valid && load_ready) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      data <= load_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/generational_handle_table_top.sv */
// Top level of the generational handle table: sequencer, slot, free-stack and retire memories.
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  -------------------------------------------
//  request   in         req_valid / req_ready  opcode, handle_index, handle_generation,
//                                              payload, payload_present, fence_value
//  response  out        rsp_valid / rsp_ready  status, out_index, out_generation,
//                                              out_payload, released, last
//
// One request is worked at a time. Resolve, retire, add of a never-used slot, null add,
// full add, clear and unknown opcodes are answered from the state that follows their accept;
// add from the free stack passes through S_ADD_GEN as well, since the stack read must land
// before the slot read. Collect pops one queue entry per cycle while responses are taken,
// limited by the single read port of the retire queue.
// Reset clears the sequencer and all counters; memory contents are never cleared, the
// fill counts (slots_in_use, free count, queue count) keep stale entries unreachable.
// A stalled response holds the sequencer in place; the output register lets the next
// request be accepted while the last response still waits.
`default_nettype none

module generational_handle_table_top #(
  parameter int SLOT_COUNT   = 64,
  parameter int RETIRE_DEPTH = 16,
  parameter int GEN_BITS     = 16,
  parameter int PAYLOAD_BITS = 32,
  localparam int IDX_W = $clog2(SLOT_COUNT)
) (
  input  logic                    clk,
  input  logic                    rst,
  // request channel
  input  logic                    req_valid,
  output logic                    req_ready,
  input  logic [2:0]              opcode,
  input  logic [IDX_W-1:0]        handle_index,
  input  logic [GEN_BITS-1:0]     handle_generation,
  input  logic [PAYLOAD_BITS-1:0] payload,
  input  logic                    payload_present,
  input  logic [63:0]             fence_value,
  // response channel
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output logic [1:0]              status,
  output logic [IDX_W-1:0]        out_index,
  output logic [GEN_BITS-1:0]     out_generation,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output logic                    released,
  output logic                    last
);

  localparam int CNT_W   = IDX_W + 1;
  localparam int QA_W    = (RETIRE_DEPTH > 1) ? $clog2(RETIRE_DEPTH) : 1;
  localparam int QC_W    = $clog2(RETIRE_DEPTH + 1);
  localparam int TS_W    = QC_W + 1;
  localparam int FENCE_W = ght_pkg::FENCE_W;
  localparam int SLOT_W  = 1 + GEN_BITS + PAYLOAD_BITS;
  localparam int QW      = FENCE_W + PAYLOAD_BITS;
  localparam int RSP_W   = 2 + IDX_W + GEN_BITS + PAYLOAD_BITS + 2;
  localparam int NW      = ght_pkg::COL_N_W;

  ght_pkg::state_t state, state_next;

  // latched request
  logic [2:0]              op_q;
  logic [IDX_W-1:0]        idx_q;
  logic [GEN_BITS-1:0]     gen_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic                    present_q;
  logic [FENCE_W-1:0]      fence_q;

  // control state
  logic [CNT_W-1:0]        slots_in_use;
  logic [CNT_W-1:0]        free_count;
  logic [QA_W-1:0]         q_head;
  logic [QC_W-1:0]         q_count;
  logic [NW-1:0]           col_n;
  logic                    pend_valid;
  logic [PAYLOAD_BITS-1:0] pend_pay;

  // memory ports
  logic              slot_we, slot_re;
  logic [IDX_W-1:0]  slot_wa, slot_ra;
  logic [SLOT_W-1:0] slot_wd, slot_rd;
  logic              free_we, free_re;
  logic [IDX_W-1:0]  free_wa, free_ra, free_rd;
  logic              q_we, q_re;
  logic [QA_W-1:0]   q_wa, q_ra;
  logic [QW-1:0]     q_wd, q_rd;

  // decoded memory words
  logic                    s_alive;
  logic [GEN_BITS-1:0]     s_gen;
  logic [PAYLOAD_BITS-1:0] s_pay;
  logic [FENCE_W-1:0]      qe_fence;
  logic [PAYLOAD_BITS-1:0] qe_pay;

  assign {s_alive, s_gen, s_pay} = slot_rd;
  assign {qe_fence, qe_pay}      = q_rd;

  // response staging
  logic                    emit, step, load_ready;
  ght_pkg::status_t        r_status;
  logic [IDX_W-1:0]        r_index;
  logic [GEN_BITS-1:0]     r_gen;
  logic [PAYLOAD_BITS-1:0] r_pay;
  logic                    r_rel, r_last;
  logic [RSP_W-1:0]        rsp_data;

  // derived conditions
  logic                accept;
  logic                live, have_free, have_unused, free_room, q_full, fence_zero;
  logic                add_from_free, pop;
  logic [GEN_BITS-1:0] gen_inc, gen_bumped;
  logic [TS_W-1:0]     tail_sum;
  logic [QA_W-1:0]     q_tail, head_inc;

  // counter updates
  logic slots_inc, free_dec, free_inc, q_push, q_pop, pend_load, pend_clear, do_clear;

  assign req_ready = (state == ght_pkg::S_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    live = (gen_q != '0) && ({1'b0, idx_q} < slots_in_use) && s_alive && (s_gen == gen_q);
    have_free     = (free_count != '0);
    have_unused   = (slots_in_use < CNT_W'(SLOT_COUNT));
    free_room     = (free_count < CNT_W'(SLOT_COUNT));
    q_full        = (q_count == QC_W'(RETIRE_DEPTH));
    fence_zero    = (fence_q == '0);
    add_from_free = present_q && have_free;
    pop = (q_count != '0) && (col_n < NW'(ght_pkg::MAX_RESULTS)) && (qe_fence <= fence_q);
    gen_inc    = s_gen + GEN_BITS'(1);
    gen_bumped = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
    tail_sum = TS_W'(q_head) + TS_W'(q_count);
    q_tail   = (tail_sum >= TS_W'(RETIRE_DEPTH)) ? QA_W'(tail_sum - TS_W'(RETIRE_DEPTH))
                                                  : QA_W'(tail_sum);
    head_inc = (q_head == QA_W'(RETIRE_DEPTH - 1)) ? '0 : q_head + QA_W'(1);
    // every non-idle state emits, except the stack-read step of add and a pop with
    // nothing pending yet
    unique case (state)
      ght_pkg::S_IDLE: emit = 1'b0;
      ght_pkg::S_ADD:  emit = !add_from_free;
      ght_pkg::S_COL:  emit = !pop || pend_valid;
      default:         emit = 1'b1;
    endcase
    step = emit ? load_ready : 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ght_pkg::S_IDLE: begin
        if (accept) begin
          if (opcode == ght_pkg::OP_ADD) begin
            state_next = ght_pkg::S_ADD;
          end else if (opcode == ght_pkg::OP_RESOLVE || opcode == ght_pkg::OP_RETIRE) begin
            state_next = ght_pkg::S_SLOT;
          end else if (opcode == ght_pkg::OP_COLLECT) begin
            state_next = ght_pkg::S_COL;
          end else begin
            state_next = ght_pkg::S_MISC;
          end
        end
      end
      ght_pkg::S_ADD: begin
        if (add_from_free) begin
          state_next = ght_pkg::S_ADD_GEN;
        end else if (step) begin
          state_next = ght_pkg::S_IDLE;
        end
      end
      ght_pkg::S_COL: begin
        if (!pop && step) begin
          state_next = ght_pkg::S_IDLE;
        end
      end
      default: begin
        if (step) begin
          state_next = ght_pkg::S_IDLE;
        end
      end
    endcase
  end

  // outputs: memory accesses, response fields, counter updates
  always_comb begin
    slot_we = 1'b0; slot_wa = idx_q; slot_wd = '0;
    slot_re = 1'b0; slot_ra = handle_index;
    free_we = 1'b0; free_wa = IDX_W'(free_count);
    free_re = 1'b0; free_ra = IDX_W'(free_count - CNT_W'(1));
    q_we = 1'b0; q_wa = q_tail; q_wd = {fence_q, s_pay};
    q_re = 1'b0; q_ra = q_head;
    r_status = ght_pkg::ST_OK; r_index = '0; r_gen = '0; r_pay = '0;
    r_rel = 1'b0; r_last = 1'b1;
    slots_inc = 1'b0; free_dec = 1'b0; free_inc = 1'b0;
    q_push = 1'b0; q_pop = 1'b0; pend_load = 1'b0; pend_clear = 1'b0; do_clear = 1'b0;
    unique case (state)
      ght_pkg::S_IDLE: begin
        // start the read that the next state needs
        if (accept) begin
          slot_re = (opcode == ght_pkg::OP_RESOLVE) || (opcode == ght_pkg::OP_RETIRE);
          free_re = (opcode == ght_pkg::OP_ADD);
          q_re    = (opcode == ght_pkg::OP_COLLECT);
        end
      end
      ght_pkg::S_ADD: begin
        if (!present_q) begin
          r_status = ght_pkg::ST_REJECT;
        end else if (have_free) begin
          slot_re = 1'b1;
          slot_ra = free_rd;
        end else if (have_unused) begin
          r_index = IDX_W'(slots_in_use);
          r_gen   = GEN_BITS'(1);
          slot_wa = IDX_W'(slots_in_use);
          slot_wd = {1'b1, GEN_BITS'(1), pay_q};
          slot_we = step;
          slots_inc = step;
        end else begin
          r_status = ght_pkg::ST_TABLE_FULL;
        end
      end
      ght_pkg::S_ADD_GEN: begin
        r_index  = free_rd;
        r_gen    = s_gen;
        slot_wa  = free_rd;
        slot_wd  = {1'b1, s_gen, pay_q};
        slot_we  = step;
        free_dec = step;
      end
      ght_pkg::S_SLOT: begin
        if (!live) begin
          r_status = ght_pkg::ST_REJECT;
        end else if (op_q == ght_pkg::OP_RESOLVE) begin
          r_pay = s_pay;
        end else if (!fence_zero && q_full) begin
          r_status = ght_pkg::ST_QUEUE_FULL;
        end else begin
          r_pay    = fence_zero ? s_pay : '0;
          r_rel    = fence_zero;
          slot_wd  = {1'b0, gen_bumped, s_pay};
          slot_we  = step;
          free_we  = step && free_room;
          free_inc = step && free_room;
          q_we     = step && !fence_zero;
          q_push   = step && !fence_zero;
        end
      end
      ght_pkg::S_COL: begin
        if (pop) begin
          // report the previous entry once it is known not to be the final one
          r_pay  = pend_pay;
          r_rel  = 1'b1;
          r_last = 1'b0;
          q_re      = step;
          q_ra      = head_inc;
          q_pop     = step;
          pend_load = step;
        end else begin
          r_pay      = pend_valid ? pend_pay : '0;
          r_rel      = pend_valid;
          pend_clear = step;
        end
      end
      ght_pkg::S_MISC: begin
        if (op_q == ght_pkg::OP_CLEAR) begin
          do_clear = step;
        end else begin
          r_status = ght_pkg::ST_REJECT;
        end
      end
      default: begin
        r_status = ght_pkg::ST_REJECT;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ght_pkg::S_IDLE;
      slots_in_use <= '0;
      free_count   <= '0;
      q_head       <= '0;
      q_count      <= '0;
      col_n        <= '0;
      pend_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (do_clear) begin
        slots_in_use <= '0;
        free_count   <= '0;
        q_head       <= '0;
        q_count      <= '0;
      end else begin
        if (slots_inc) begin
          slots_in_use <= slots_in_use + CNT_W'(1);
        end
        if (free_inc) begin
          free_count <= free_count + CNT_W'(1);
        end else if (free_dec) begin
          free_count <= free_count - CNT_W'(1);
        end
        if (q_push) begin
          q_count <= q_count + QC_W'(1);
        end else if (q_pop) begin
          q_count <= q_count - QC_W'(1);
          q_head  <= head_inc;
        end
      end
      if (accept) begin
        col_n <= '0;
      end else if (q_pop) begin
        col_n <= col_n + NW'(1);
      end
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_clear) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // request and pending payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= opcode;
      idx_q     <= handle_index;
      gen_q     <= handle_generation;
      pay_q     <= payload;
      present_q <= payload_present;
      fence_q   <= fence_value;
    end
    if (pend_load) begin
      pend_pay <= qe_pay;
    end
  end

  ght_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (slot_wa),
    .wr_data (slot_wd),
    .rd_en   (slot_re),
    .rd_addr (slot_ra),
    .rd_data (slot_rd)
  );

  ght_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_free_ram (
    .clk     (clk),
    .wr_en   (free_we),
    .wr_addr (free_wa),
    .wr_data (idx_q),
    .rd_en   (free_re),
    .rd_addr (free_ra),
    .rd_data (free_rd)
  );

  ght_ram #(.WIDTH(QW), .DEPTH(RETIRE_DEPTH)) u_retire_ram (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (q_wa),
    .wr_data (q_wd),
    .rd_en   (q_re),
    .rd_addr (q_ra),
    .rd_data (q_rd)
  );

  ght_out_reg #(.WIDTH(RSP_W)) u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (emit),
    .load_ready (load_ready),
    .load_data  ({r_status, r_index, r_gen, r_pay, r_rel, r_last}),
    .out_valid  (rsp_valid),
    .out_ready  (rsp_ready),
    .out_data   (rsp_data)
  );

  assign {status, out_index, out_generation, out_payload, released, last} = rsp_data;

endmodule

`default_nettype wire

/* verif/generational_handle_table_checker.sv */
// Request/response checker for the generational handle table: shadow table and in-order compare.
`timescale 1ns / 100ps

module generational_handle_table_checker #(
  parameter int SLOTS  = 64,
  parameter int QDEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic [2:0]  opcode,
  input  logic [5:0]  handle_index,
  input  logic [15:0] handle_generation,
  input  logic [31:0] payload,
  input  logic        payload_present,
  input  logic [63:0] fence_value,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic [1:0]  status,
  input  logic [5:0]  out_index,
  input  logic [15:0] out_generation,
  input  logic [31:0] out_payload,
  input  logic        released,
  input  logic        last,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    ght_pkg::status_t status;
    logic [5:0]       index;
    logic [15:0]      generation;
    logic [31:0]      tag;
    logic             rel;
    logic             fin;
  } table_result_t;

  // Shadow copy of the slot table, free stack and retire queue.
  logic        slot_live  [SLOTS];
  logic [15:0] slot_gen   [SLOTS];
  logic [31:0] slot_tag   [SLOTS];
  logic [5:0]  free_slots [SLOTS];
  logic [63:0] q_fence    [QDEPTH];
  logic [31:0] q_tag      [QDEPTH];
  int unsigned used_slots;
  int unsigned free_depth;
  int unsigned q_head;
  int unsigned q_count;

  table_result_t awaited_results[$];
  int            fails = 0;

  task automatic table_clear();
    for (int s = 0; s < SLOTS; s++) begin
      slot_live[s] = 1'b0;
      slot_gen[s]  = '0;
      slot_tag[s]  = '0;
    end
    used_slots = 0;
    free_depth = 0;
    q_head     = 0;
    q_count    = 0;
  endtask

  task automatic await_result(input ght_pkg::status_t st, input logic [5:0] idx,
                              input logic [15:0] gen, input logic [31:0] tag,
                              input logic rel, input logic fin);
    table_result_t r;
    r.status     = st;
    r.index      = idx;
    r.generation = gen;
    r.tag        = tag;
    r.rel        = rel;
    r.fin        = fin;
    awaited_results.push_back(r);
  endtask

  function automatic bit handle_live(input logic [5:0] idx, input logic [15:0] gen);
    return gen != '0 && idx < used_slots && slot_live[idx] && slot_gen[idx] == gen;
  endfunction

  task automatic predict_table_request();
    int unsigned s;
    int          n;
    bit          more;
    logic [31:0] tag;
    logic [15:0] next_gen;
    case (opcode)
      ght_pkg::OP_ADD: begin
        if (!payload_present) begin
          await_result(ght_pkg::ST_REJECT, '0, '0, '0, 1'b0, 1'b1);
        end else if (free_depth == 0 && used_slots >= SLOTS) begin
          await_result(ght_pkg::ST_TABLE_FULL, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          if (free_depth > 0) begin
            free_depth--;
            s = 32'(free_slots[free_depth]);
          end else begin
            s = used_slots;
            used_slots++;
            slot_gen[s] = 16'd1;
          end
          slot_live[s] = 1'b1;
          slot_tag[s]  = payload;
          await_result(ght_pkg::ST_OK, s[5:0], slot_gen[s], '0, 1'b0, 1'b1);
        end
      end
      ght_pkg::OP_RESOLVE: begin
        if (handle_live(handle_index, handle_generation))
          await_result(ght_pkg::ST_OK, '0, '0, slot_tag[handle_index], 1'b0, 1'b1);
        else
          await_result(ght_pkg::ST_REJECT, '0, '0, '0, 1'b0, 1'b1);
      end
      ght_pkg::OP_RETIRE: begin
        if (!handle_live(handle_index, handle_generation)) begin
          await_result(ght_pkg::ST_REJECT, '0, '0, '0, 1'b0, 1'b1);
        end else if (fence_value != '0 && q_count >= QDEPTH) begin
          await_result(ght_pkg::ST_QUEUE_FULL, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          tag = slot_tag[handle_index];
          slot_live[handle_index] = 1'b0;
          // generation zero marks an invalid handle, so skip it on wrap
          next_gen = slot_gen[handle_index] + 16'd1;
          slot_gen[handle_index] = (next_gen == '0) ? 16'd1 : next_gen;
          if (free_depth < SLOTS) begin
            free_slots[free_depth] = handle_index;
            free_depth++;
          end
          if (fence_value == '0) begin
            await_result(ght_pkg::ST_OK, '0, '0, tag, 1'b1, 1'b1);
          end else begin
            q_fence[(q_head + q_count) % QDEPTH] = fence_value;
            q_tag[(q_head + q_count) % QDEPTH]   = tag;
            q_count++;
            await_result(ght_pkg::ST_OK, '0, '0, '0, 1'b0, 1'b1);
          end
        end
      end
      ght_pkg::OP_COLLECT: begin
        n    = 0;
        more = q_count > 0 && q_fence[q_head] <= fence_value;
        if (!more)
          await_result(ght_pkg::ST_OK, '0, '0, '0, 1'b0, 1'b1);
        while (more) begin
          tag     = q_tag[q_head];
          q_head  = (q_head + 1) % QDEPTH;
          q_count--;
          n++;
          more = n < ght_pkg::MAX_RESULTS && q_count > 0 && q_fence[q_head] <= fence_value;
          await_result(ght_pkg::ST_OK, '0, '0, tag, 1'b1, !more);
        end
      end
      ght_pkg::OP_CLEAR: begin
        table_clear();
        await_result(ght_pkg::ST_OK, '0, '0, '0, 1'b0, 1'b1);
      end
      default: await_result(ght_pkg::ST_REJECT, '0, '0, '0, 1'b0, 1'b1);
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  task automatic check_response();
    table_result_t want;
    if (awaited_results.size() == 0) begin
      $error("response with nothing outstanding: status %0d out_payload 0x%0h",
             status, out_payload);
      fails++;
    end else begin
      want = awaited_results[0];
      awaited_results.delete(0);
      check_field("status", 32'(want.status), 32'(status));
      check_field("out_index", 32'(want.index), 32'(out_index));
      check_field("out_generation", 32'(want.generation), 32'(out_generation));
      check_field("out_payload", want.tag, out_payload);
      check_field("released", 32'(want.rel), 32'(released));
      check_field("last", 32'(want.fin), 32'(last));
    end
  endtask

  // Predict before compare: a response can never belong to a request taken on the same edge.
  always @(posedge clk) begin
    if (rst) begin
      table_clear();
      awaited_results.delete();
    end else begin
      if (req_valid && req_ready)
        predict_table_request();
      if (rsp_valid && rsp_ready)
        check_response();
    end
    fail_count <= fails;
    pending    <= awaited_results.size();
  end

endmodule

/* verif/generational_handle_table_top_tb.sv */
// Testbench top of the generational handle table: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 100ps

module generational_handle_table_top_tb;

  // Generous bound: far above what the longest collects need under the heaviest stalls.
  localparam int          CYCLE_LIMIT     = 200_000;
  localparam int          DRAIN_CYCLES    = 40;
  localparam int          PHASE_REQUESTS  = 136;
  localparam int          BLOCK_REQUESTS  = 32;
  localparam logic [2:0]  OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0]  OP_LAST_UNUSED  = 3'd7;
  localparam logic [63:0] FENCE_MAX       = '1;
  localparam logic [15:0] GEN_MAX         = '1;
  localparam logic [31:0] TAG_MAX         = '1;

  // Request mixes: fill the table, drain it through retire and collect, or a bit of both.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND} req_mix_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  logic [2:0]  opcode;
  logic [5:0]  handle_index;
  logic [15:0] handle_generation;
  logic [31:0] payload;
  logic        payload_present;
  logic [63:0] fence_value;
  logic        rsp_valid;
  logic        rsp_ready;
  logic [1:0]  status;
  logic [5:0]  out_index;
  logic [15:0] out_generation;
  logic [31:0] out_payload;
  logic        released;
  logic        last;

  int fail_count;
  int pending;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Handles seen in add responses, reused as live or stale handles for resolve and retire.
  logic        seen_handle [64];
  logic [15:0] seen_gen    [64];

  generational_handle_table_top uut (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (req_valid),
    .req_ready         (req_ready),
    .opcode            (opcode),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .payload           (payload),
    .payload_present   (payload_present),
    .fence_value       (fence_value),
    .rsp_valid         (rsp_valid),
    .rsp_ready         (rsp_ready),
    .status            (status),
    .out_index         (out_index),
    .out_generation    (out_generation),
    .out_payload       (out_payload),
    .released          (released),
    .last              (last)
  );

  generational_handle_table_checker handle_checker (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (req_valid),
    .req_ready         (req_ready),
    .opcode            (opcode),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .payload           (payload),
    .payload_present   (payload_present),
    .fence_value       (fence_value),
    .rsp_valid         (rsp_valid),
    .rsp_ready         (rsp_ready),
    .status            (status),
    .out_index         (out_index),
    .out_generation    (out_generation),
    .out_payload       (out_payload),
    .released          (released),
    .last              (last),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("generational_handle_table_top_tb failed");
      $finish;
    end
  end

  // Stall the response side at random; the idle percentage changes per phase.
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Record handles from successful add responses: only an add answers ok with a nonzero
  // generation.
  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 64; s++) begin
        seen_handle[s] <= 1'b0;
        seen_gen[s]    <= '0;
      end
    end else if (rsp_valid && rsp_ready && status == ght_pkg::ST_OK && !released && last &&
                 out_generation != '0) begin
      seen_handle[out_index] <= 1'b1;
      seen_gen[out_index]    <= out_generation;
    end
  end

  // Present one request and hold it until accepted; idle first at random.
  task automatic send_req(input logic [2:0] op, input logic [5:0] idx, input logic [15:0] gen,
                          input logic [31:0] tag, input logic present, input logic [63:0] fence);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid         <= 1'b1;
    opcode            <= op;
    handle_index      <= idx;
    handle_generation <= gen;
    payload           <= tag;
    payload_present   <= present;
    fence_value       <= fence;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Build one random request of the given mix. Fields an opcode ignores stay random.
  task automatic send_random(input req_mix_t mix);
    int          roll;
    int          sel;
    int          tries;
    int          t_add;
    int          t_res;
    int          t_ret;
    int          t_col;
    int          t_clr;
    logic [2:0]  op;
    logic [5:0]  idx;
    logic [15:0] gen;
    logic [31:0] tag;
    logic        present;
    logic [63:0] fence;
    case (mix)
      MIX_FILL: begin
        t_add = 85; t_res = 93; t_ret = 97; t_col = 100; t_clr = 100;
      end
      MIX_DRAIN: begin
        t_add = 15; t_res = 30; t_ret = 75; t_col = 95; t_clr = 97;
      end
      default: begin
        t_add = 35; t_res = 55; t_ret = 80; t_col = 92; t_clr = 95;
      end
    endcase
    idx     = 6'($urandom_range(63));
    gen     = 16'($urandom);
    tag     = $urandom;
    present = 1'($urandom_range(1));
    fence   = {$urandom, $urandom};
    roll    = $urandom_range(99);
    if (roll < t_add)      op = ght_pkg::OP_ADD;
    else if (roll < t_res) op = ght_pkg::OP_RESOLVE;
    else if (roll < t_ret) op = ght_pkg::OP_RETIRE;
    else if (roll < t_col) op = ght_pkg::OP_COLLECT;
    else if (roll < t_clr) op = ght_pkg::OP_CLEAR;
    else                   op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));

    if (op == ght_pkg::OP_ADD) begin
      // mostly real resources, now and then a null add; hit both payload extremes
      present = ($urandom_range(9) != 0);
      sel     = $urandom_range(19);
      if (sel == 0)      tag = '0;
      else if (sel == 1) tag = TAG_MAX;
    end

    if (op == ght_pkg::OP_RESOLVE || op == ght_pkg::OP_RETIRE) begin
      sel = $urandom_range(99);
      if (sel < 85) begin
        // prefer a slot that has handed out a handle; that handle may since have gone stale
        for (tries = 0; tries < 8 && !seen_handle[idx]; tries++)
          idx = 6'($urandom_range(63));
        gen = seen_gen[idx];
        if (sel >= 80)
          gen = '0;
        else if (sel >= 70)
          gen = gen + (($urandom_range(1) != 0) ? 16'd1 : GEN_MAX);
      end
    end

    if (op == ght_pkg::OP_RETIRE) begin
      sel = $urandom_range(99);
      if (sel < 30)      fence = '0;
      else if (sel < 40) fence = FENCE_MAX;
      else if (sel < 75) fence = 64'($urandom_range(1, 300));
    end else if (op == ght_pkg::OP_COLLECT) begin
      sel = $urandom_range(99);
      if (sel < 15)      fence = '0;
      else if (sel < 30) fence = FENCE_MAX;
      else if (sel < 80) fence = 64'($urandom_range(0, 300));
    end
    send_req(op, idx, gen, tag, present, fence);
  endtask

  // Open with a fill burst so the table runs full, then switch mixes block by block.
  task automatic run_phase(input int count, input int fill_len);
    req_mix_t mix;
    mix = MIX_FILL;
    for (int i = 0; i < count; i++) begin
      if (i >= fill_len && (i - fill_len) % BLOCK_REQUESTS == 0)
        mix = req_mix_t'($urandom_range(2));
      send_random(mix);
    end
  endtask

  initial begin
    rst               <= 1'b1;
    req_valid         <= 1'b0;
    opcode            <= ght_pkg::OP_ADD;
    handle_index      <= '0;
    handle_generation <= '0;
    payload           <= '0;
    payload_present   <= 1'b0;
    fence_value       <= '0;
    send_idle_pct = 35;
    recv_idle_pct = 63;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed requests: every opcode and each corner case on a fresh table.
    send_req(ght_pkg::OP_COLLECT, 6'd0, 16'd0, 32'd0, 1'b0, 64'd0);      // nothing queued
    send_req(ght_pkg::OP_ADD, 6'd0, 16'd0, 32'hA5A5_0001, 1'b0, 64'd0);  // null resource
    send_req(ght_pkg::OP_ADD, 6'd0, 16'd0, 32'd0, 1'b1, 64'd0);          // slot 0, gen 1
    send_req(ght_pkg::OP_ADD, 6'd63, GEN_MAX, TAG_MAX, 1'b1, FENCE_MAX); // slot 1, gen 1
    send_req(ght_pkg::OP_RESOLVE, 6'd0, 16'd1, 32'd0, 1'b0, 64'd0);
    send_req(ght_pkg::OP_RESOLVE, 6'd1, 16'd1, 32'd0, 1'b1, FENCE_MAX);
    send_req(ght_pkg::OP_RESOLVE, 6'd1, 16'd0, 32'd0, 1'b0, 64'd0);      // generation zero
    send_req(ght_pkg::OP_RESOLVE, 6'd63, 16'd1, 32'd0, 1'b0, 64'd0);     // slot never taken
    send_req(ght_pkg::OP_RESOLVE, 6'd0, 16'd2, 32'd0, 1'b0, 64'd0);      // generation mismatch
    send_req(ght_pkg::OP_RETIRE, 6'd1, 16'd1, 32'd0, 1'b0, 64'd0);       // release at once
    send_req(ght_pkg::OP_RESOLVE, 6'd1, 16'd1, 32'd0, 1'b0, 64'd0);      // stale handle
    send_req(ght_pkg::OP_RETIRE, 6'd1, 16'd1, 32'd0, 1'b0, 64'd0);       // retire twice
    send_req(ght_pkg::OP_ADD, 6'd0, 16'd0, 32'h1234_5678, 1'b1, 64'd0);  // slot 1 back, gen 2
    send_req(ght_pkg::OP_RETIRE, 6'd1, 16'd2, 32'd0, 1'b0, FENCE_MAX);   // behind max fence
    send_req(ght_pkg::OP_RETIRE, 6'd0, 16'd1, 32'd0, 1'b0, 64'd5);       // queued
    send_req(ght_pkg::OP_COLLECT, 6'd0, 16'd0, 32'd0, 1'b0, 64'd4);      // head not yet due
    send_req(ght_pkg::OP_COLLECT, 6'd0, 16'd0, 32'd0, 1'b0, FENCE_MAX);  // both pop
    send_req(OP_FIRST_UNUSED, 6'd2, 16'd3, 32'd4, 1'b1, 64'd5);
    send_req(OP_FIRST_UNUSED + 3'd1, 6'd0, 16'd1, 32'd0, 1'b1, 64'd0);
    send_req(OP_LAST_UNUSED, 6'd63, GEN_MAX, TAG_MAX, 1'b1, FENCE_MAX);
    send_req(ght_pkg::OP_CLEAR, 6'd0, 16'd0, 32'd0, 1'b0, 64'd0);
    send_req(ght_pkg::OP_RESOLVE, 6'd0, 16'd1, 32'd0, 1'b0, 64'd0);      // gone after clear
    send_req(ght_pkg::OP_ADD, 6'd0, 16'd0, 32'hCAFE_F00D, 1'b1, 64'd0);  // slot 0, gen 1 again

    // Random traffic: sender idles lightly while the receiver stalls hard, then swap, then neither idles.
    run_phase(PHASE_REQUESTS, 80);
    send_idle_pct = 63;
    recv_idle_pct = 35;
    run_phase(PHASE_REQUESTS, 24);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(PHASE_REQUESTS, 24);

    // Drop valid, let the outstanding count catch up, then drain.
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("generational_handle_table_top_tb passed");
    else
      $display("generational_handle_table_top_tb failed");
    $finish;
  end

endmodule
